// ===== design/twt_pkg.sv =====
// Shared types, character codes and byte classification for the text word tokenizer.
// Used by twt_step, twt_fifo and text_word_tokenizer_top; no dependencies.
`default_nettype none
package twt_pkg;

  localparam int unsigned TWT_MAX_RESULTS = 3;
  localparam int unsigned TWT_FIFO_DEPTH  = 4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DIGIT = 2'd1,
    MODE_WORD  = 2'd2
  } twt_mode_t;

  typedef struct packed {
    twt_mode_t  mode;
    logic [7:0] held;
    logic       quote_pending;
  } twt_state_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_last;
  } twt_result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
           ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/text_word_tokenizer_top.sv =====
// Text word tokenizer top level: tokenizer state registers, step logic and result queue.
// Depends on twt_pkg, twt_step and twt_fifo.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one text byte per request, with
//   in_end_of_text set to flush the held byte and close the text.
//   Output channel (out_valid/out_stall) carries lowercased token bytes, one per
//   cycle while out_stall is low, with out_token_last marking the final byte of each token.
//   Each request yields zero to three results; they enter a FIFO_DEPTH-entry
//   result queue in the accepting cycle, and an empty queue offers the first in the next cycle.
//   Throughput: one request per cycle while the queue has room for three more
//   entries; the output side drains one result per cycle while out_stall is low, so a
//   stream making more than one result per byte is paced by the output port.
//   When the receiver stalls, results stay in the queue and in_stall rises once
//   fewer than three free entries remain.
//   Reset (rst_n low, synchronous) empties the queue and returns the scanner to
//   idle with no byte held and no apostrophe pending.
`default_nettype none
module text_word_tokenizer_top #(
  parameter int unsigned FIFO_DEPTH = twt_pkg::TWT_FIFO_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_token_byte,
  output logic            out_token_last
);
  import twt_pkg::*;

  twt_state_t  state_r, state_nxt;
  twt_result_t step_res [TWT_MAX_RESULTS];
  logic [1:0]  step_count;
  logic        in_accept;
  logic        has_room;
  logic        pop;
  twt_result_t head;

  assign in_stall  = !has_room;
  assign in_accept = in_valid && has_room;
  assign pop       = out_valid && !out_stall;

  twt_step u_step (
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .cur         (state_r),
    .nxt         (state_nxt),
    .res         (step_res),
    .res_count   (step_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_IDLE, held: 8'h00, quote_pending: 1'b0};
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  twt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (in_accept ? step_count : 2'd0),
    .push_data  (step_res),
    .pop        (pop),
    .head       (head),
    .not_empty  (out_valid),
    .has_room   (has_room)
  );

  assign out_token_byte = head.token_byte;
  assign out_token_last = head.token_last;

endmodule
`default_nettype wire

// ===== design/twt_step.sv =====
// Combinational tokenizer step: classifies one byte against the held state and
// produces up to three result entries and the next state. Depends on twt_pkg.
`default_nettype none
module twt_step (
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_text,
  input  wire twt_pkg::twt_state_t cur,
  output twt_pkg::twt_state_t      nxt,
  output twt_pkg::twt_result_t     res [twt_pkg::TWT_MAX_RESULTS],
  output logic [1:0]               res_count
);
  import twt_pkg::*;

  logic [7:0] lc;
  logic       do_start;
  logic [1:0] slot;

  assign lc = to_lower(text_byte);

  always_comb begin
    nxt       = cur;
    res_count = 2'd0;
    do_start  = 1'b0;
    slot      = 2'd0;
    for (int i = 0; i < TWT_MAX_RESULTS; i++) begin
      res[i] = '{token_byte: lc, token_last: 1'b1};
    end

    if (end_of_text) begin
      if (cur.mode == MODE_DIGIT || cur.mode == MODE_WORD) begin
        res[0]    = '{token_byte: cur.held, token_last: 1'b1};
        res_count = 2'd1;
        if (cur.mode == MODE_WORD && cur.quote_pending) begin
          res[1]    = '{token_byte: CH_QUOTE, token_last: 1'b1};
          res_count = 2'd2;
        end
      end
      nxt.mode          = MODE_IDLE;
      nxt.quote_pending = 1'b0;
    end else begin
      case (cur.mode)
        MODE_DIGIT: begin
          if (is_digit(text_byte) || is_letter(text_byte)) begin
            res[0]    = '{token_byte: cur.held, token_last: 1'b0};
            res_count = 2'd1;
            nxt.held  = lc;
          end else begin
            res[0]   = '{token_byte: cur.held, token_last: 1'b1};
            do_start = 1'b1;
            slot     = 2'd1;
          end
        end
        MODE_WORD: begin
          if (cur.quote_pending) begin
            if (is_letter(text_byte)) begin
              // apostrophe sits between two letters: keep it inside the word
              res[0]            = '{token_byte: cur.held, token_last: 1'b0};
              res[1]            = '{token_byte: CH_QUOTE, token_last: 1'b0};
              res_count         = 2'd2;
              nxt.held          = lc;
              nxt.quote_pending = 1'b0;
            end else begin
              res[0]   = '{token_byte: cur.held, token_last: 1'b1};
              res[1]   = '{token_byte: CH_QUOTE, token_last: 1'b1};
              do_start = 1'b1;
              slot     = 2'd2;
            end
          end else if (is_letter(text_byte)) begin
            res[0]    = '{token_byte: cur.held, token_last: 1'b0};
            res_count = 2'd1;
            nxt.held  = lc;
          end else if (text_byte == CH_QUOTE) begin
            nxt.quote_pending = 1'b1;
          end else begin
            res[0]   = '{token_byte: cur.held, token_last: 1'b1};
            do_start = 1'b1;
            slot     = 2'd1;
          end
        end
        default: begin
          do_start = 1'b1;
          slot     = 2'd0;
        end
      endcase

      // open a new token from idle after whatever the old one emitted; other non-blank bytes become one-byte tokens
      if (do_start) begin
        nxt.mode          = MODE_IDLE;
        nxt.quote_pending = 1'b0;
        res_count         = slot;
        if (is_digit(text_byte)) begin
          nxt.mode = MODE_DIGIT;
          nxt.held = lc;
        end else if (is_letter(text_byte)) begin
          nxt.mode = MODE_WORD;
          nxt.held = lc;
        end else if (!is_blank(text_byte)) begin
          res_count = slot + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/twt_fifo.sv =====
// Result queue: takes up to three entries per cycle, delivers one per cycle while pop is high.
// Depends on twt_pkg for the entry type and the push width.
`default_nettype none
module twt_fifo #(
  parameter int unsigned DEPTH = twt_pkg::TWT_FIFO_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           push_count,
  input  wire twt_pkg::twt_result_t push_data [twt_pkg::TWT_MAX_RESULTS],
  input  wire logic                 pop,
  output twt_pkg::twt_result_t      head,
  output logic                      not_empty,
  output logic                      has_room
);
  import twt_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] RoomLimit = CntW'(DEPTH - TWT_MAX_RESULTS);

  twt_result_t     mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [PtrW-1:0] slot_ptr [TWT_MAX_RESULTS];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    slot_ptr[0] = wr_ptr_r;
    for (int i = 1; i < TWT_MAX_RESULTS; i++) begin
      slot_ptr[i] = ptr_inc(slot_ptr[i-1]);
    end
    wr_ptr_nxt = wr_ptr_r;
    for (int i = 0; i < TWT_MAX_RESULTS; i++) begin
      if (2'(i) < push_count) begin
        wr_ptr_nxt = ptr_inc(slot_ptr[i]);
      end
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push_count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TWT_MAX_RESULTS; i++) begin
      if (2'(i) < push_count) begin
        mem_r[slot_ptr[i]] <= push_data[i];
      end
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  // hold off requests unless a worst-case burst of results fits
  assign has_room  = (count_r <= RoomLimit);

endmodule
`default_nettype wire

// ===== verif/text_word_tokenizer_top_tb.sv =====
// Self-checking testbench for text_word_tokenizer_top: directed and random text bytes,
// token bytes predicted in a scoreboard class and checked in order on the result channel.
// Depends on twt_pkg and the text_word_tokenizer_top RTL.
`default_nettype none
module text_word_tokenizer_top_tb;
  import twt_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES = 10;

  class token_tracker;
    twt_mode_t   mode;
    logic [7:0]  held;
    logic        quote_wait;
    twt_result_t due_tokens[$];
    int          errors;

    function new();
      mode       = MODE_IDLE;
      held       = 8'h00;
      quote_wait = 1'b0;
      errors     = 0;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function bit digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SPACE;
    endfunction

    function logic [7:0] fold(logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function void emit(logic [7:0] b, logic l);
      twt_result_t r;
      r.token_byte = b;
      r.token_last = l;
      due_tokens.insert(due_tokens.size(), r);
    endfunction

    // Byte seen with no token open.
    function void open_token(logic [7:0] c);
      mode       = MODE_IDLE;
      quote_wait = 1'b0;
      if (blank(c)) return;
      if (digit(c)) begin
        mode = MODE_DIGIT;
        held = fold(c);
      end else if (letter(c)) begin
        mode = MODE_WORD;
        held = fold(c);
      end else begin
        emit(fold(c), 1'b1);
      end
    endfunction

    function void note_request(logic [7:0] c, logic eot);
      if (eot) begin
        if (mode == MODE_DIGIT || mode == MODE_WORD) begin
          emit(held, 1'b1);
          if (mode == MODE_WORD && quote_wait) emit(CH_QUOTE, 1'b1);
        end
        mode       = MODE_IDLE;
        quote_wait = 1'b0;
        return;
      end
      case (mode)
        MODE_DIGIT: begin
          if (digit(c) || letter(c)) begin
            emit(held, 1'b0);
            held = fold(c);
          end else begin
            emit(held, 1'b1);
            open_token(c);
          end
        end
        MODE_WORD: begin
          if (quote_wait) begin
            if (letter(c)) begin
              emit(held, 1'b0);
              emit(CH_QUOTE, 1'b0);
              held       = fold(c);
              quote_wait = 1'b0;
            end else begin
              emit(held, 1'b1);
              emit(CH_QUOTE, 1'b1);
              open_token(c);
            end
          end else if (letter(c)) begin
            emit(held, 1'b0);
            held = fold(c);
          end else if (c == CH_QUOTE) begin
            quote_wait = 1'b1;
          end else begin
            emit(held, 1'b1);
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
    endfunction

    function void check_result(logic [7:0] b, logic l);
      twt_result_t want;
      if (due_tokens.size() == 0) begin
        $display("%0t: unexpected result: expected none, got byte %02h last %0b",
                 $time, b, l);
        errors++;
        return;
      end
      want = due_tokens.pop_front();
      if (b !== want.token_byte) begin
        $display("%0t: token_byte mismatch: expected %02h, got %02h",
                 $time, want.token_byte, b);
        errors++;
      end
      if (l !== want.token_last) begin
        $display("%0t: token_last mismatch: expected %0b, got %0b",
                 $time, want.token_last, l);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_tokens.size();
    endfunction
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte   = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_token_byte;
  logic       out_token_last;

  int unsigned  idle_pct  = 0;
  int unsigned  stall_pct = 0;
  int unsigned  quiet     = 0;
  token_tracker tracker   = new();

  text_word_tokenizer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_byte (out_token_byte),
    .out_token_last (out_token_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) tracker.note_request(in_text_byte, in_end_of_text);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_token_byte, out_token_last);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("text_word_tokenizer_top_tb: errors");
      $finish;
    end
  end

  // Hold the request until accepted, then idle for a random gap.
  task automatic push(input logic [7:0] b, input logic eot);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push(s[i], 1'b0);
  endtask

  // Stop sending until every predicted token byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  task automatic push_random();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(99);
    b    = 8'($urandom_range(255));
    if (pick < 40) begin
      b = ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(25));
    end else if (pick < 55) begin
      b = CH_ZERO + 8'($urandom_range(9));
    end else if (pick < 67) begin
      case ($urandom_range(3))
        0: b = CH_TAB;
        1: b = CH_LF;
        2: b = CH_CR;
        default: b = CH_SPACE;
      endcase
    end else if (pick < 77) begin
      b = CH_QUOTE;
    end
    push(b, pick >= 93);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Inner apostrophe, end of text with an all-ones byte that must be ignored.
    push_text("Don't");
    push(8'hFF, 1'b1);
    // Digit token swallowing letters, closed by a blank.
    push_text("9Zx\t");
    // Apostrophe followed by a non-letter splits the word.
    push_text("b'1");
    push_text("A'\n");
    // Pending apostrophe flushed by end of text, then an empty flush.
    push_text("z'");
    push(8'h00, 1'b1);
    push(8'h00, 1'b1);
    push_text("\r @[`{");
    push(8'h00, 1'b0);
    push(8'hFF, 1'b0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < 33; n++) push_random();
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("text_word_tokenizer_top_tb: clean");
    end else begin
      $display("text_word_tokenizer_top_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
